// File: rtl/lmrs_pkg.sv
// ----------------------------------------------------------------------------
// lmrs_pkg
// Shared constants, types and codes of the LED matrix row scan driver.
// ----------------------------------------------------------------------------
package lmrs_pkg;

  localparam int COLUMNS   = 128;
  localparam int ROWS      = 64;
  localparam int COL_W     = $clog2(COLUMNS);
  localparam int ROW_W     = $clog2(ROWS + 1);
  localparam int MEM_DEPTH = ROWS * COLUMNS;
  localparam int MEM_AW    = $clog2(MEM_DEPTH);

  localparam int ADDR_W    = 13;
  localparam int SETTLE_W  = 10;
  localparam int DELAY_W   = 11;
  localparam int TICK_W    = 16;
  localparam int FRAME_W   = 32;
  localparam int CFG_W     = 16;
  localparam int CFG_IW    = 2;

  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  localparam logic [CFG_IW-1:0] CFG_SETTLE = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_EXTRA  = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_PERIOD = 2'd2;

  localparam logic [SETTLE_W-1:0] RST_SETTLE = 10'd90;
  localparam logic [SETTLE_W-1:0] RST_EXTRA  = 10'd300;
  localparam logic [TICK_W-1:0]   RST_PERIOD = 16'd16667;
  localparam logic [TICK_W-1:0]   TICK_MAX   = 16'hFFFF;

  typedef enum logic [3:0] {
    PH_COLDATA,
    PH_CLKHI,
    PH_CLKLO,
    PH_SETTLE,
    PH_OELOW,
    PH_LATHI,
    PH_LATLO,
    PH_ROWDATA,
    PH_RCLKHI,
    PH_RCLKLO,
    PH_OEHI,
    PH_WAIT
  } phase_t;

  typedef struct packed {
    logic [SETTLE_W-1:0] settle;
    logic [SETTLE_W-1:0] extra;
    logic [TICK_W-1:0]   period;
  } cfg_t;

  typedef struct packed {
    logic cc;
    logic cl;
    logic rd;
    logic rc;
    logic oe;
  } pins_t;

  typedef struct packed {
    logic               rd_en;
    logic [MEM_AW-1:0]  rd_addr;
    logic               cd_load;
    logic               cd_blank;
    pins_t              pins;
    logic [FRAME_W-1:0] frames;
  } scan_upd_t;

endpackage

// File: rtl/lmrs_if.sv
// ----------------------------------------------------------------------------
// lmrs_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface lmrs_in_if;
  logic                       valid;
  logic                       ready;
  logic                       opcode;
  logic [lmrs_pkg::ADDR_W-1:0] pixel_address;
  logic                       pixel_on;

  modport source (output valid, output opcode, output pixel_address, output pixel_on,
                  input ready);
  modport sink (input valid, input opcode, input pixel_address, input pixel_on,
                output ready);
endinterface

interface lmrs_out_if;
  logic                        valid;
  logic                        ready;
  logic                        col_sdi;
  logic                        col_sck;
  logic                        col_lat;
  logic                        row_sdi;
  logic                        row_sck;
  logic                        oe_n;
  logic [lmrs_pkg::FRAME_W-1:0] frame_count;

  modport source (output valid, output col_sdi, output col_sck, output col_lat,
                  output row_sdi, output row_sck, output oe_n,
                  output frame_count, input ready);
  modport sink (input valid, input col_sdi, input col_sck, input col_lat,
                input row_sdi, input row_sck, input oe_n,
                input frame_count, output ready);
endinterface

// File: rtl/lmrs_frame_mem.sv
// ----------------------------------------------------------------------------
// lmrs_frame_mem
// One-bit frame store with a registered read port and a clearing pass
// that writes zeros to every pixel after reset.
// ----------------------------------------------------------------------------
module lmrs_frame_mem (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        we,
  input  logic [lmrs_pkg::MEM_AW-1:0] waddr,
  input  logic                        wdata,
  input  logic                        re,
  input  logic [lmrs_pkg::MEM_AW-1:0] raddr,
  output logic                        rdata,
  output logic                        busy
);

  logic                        mem [lmrs_pkg::MEM_DEPTH];
  logic [lmrs_pkg::MEM_AW-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b1;
      clr_addr <= '0;
    end else if (busy) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == lmrs_pkg::MEM_AW'(lmrs_pkg::MEM_DEPTH - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      mem[clr_addr] <= 1'b0;
    end else if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/lmrs_scan_ctrl.sv
// ----------------------------------------------------------------------------
// lmrs_scan_ctrl
// Scan sequencer: phase, column and row counters, settle delay, frame
// timing and pin levels. Issues the frame store read for each column of a visible row.
// ----------------------------------------------------------------------------
module lmrs_scan_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 tick,
  input  lmrs_pkg::cfg_t       cfg,
  output lmrs_pkg::scan_upd_t  upd
);

  lmrs_pkg::phase_t                phase, phase_next;
  logic [lmrs_pkg::COL_W-1:0]      col, col_next;
  logic [lmrs_pkg::ROW_W-1:0]      row, row_next;
  logic [lmrs_pkg::DELAY_W-1:0]    delay, delay_next;
  logic [lmrs_pkg::TICK_W-1:0]     elapsed, elapsed_next;
  logic [lmrs_pkg::FRAME_W-1:0]    frames, frames_next;
  lmrs_pkg::pins_t                 pins, pins_next;

  logic [lmrs_pkg::TICK_W-1:0]     elapsed_inc;
  logic [lmrs_pkg::DELAY_W-1:0]    delay_load;
  logic [lmrs_pkg::DELAY_W-1:0]    delay_dec;
  logic                            period_done;
  logic                            last_col;
  logic                            last_row;
  logic                            blank;
  logic                            fetch;
  logic                            frame_start;

  assign elapsed_inc = (elapsed == lmrs_pkg::TICK_MAX) ? elapsed : elapsed + 1'b1;
  assign period_done = (elapsed_inc >= cfg.period);
  assign last_col    = (col == lmrs_pkg::COL_W'(lmrs_pkg::COLUMNS - 1));
  assign last_row    = (row == lmrs_pkg::ROW_W'(lmrs_pkg::ROWS));
  assign blank       = (row >= lmrs_pkg::ROW_W'(lmrs_pkg::ROWS));
  assign delay_load  = lmrs_pkg::DELAY_W'(cfg.settle)
                     + ((row == lmrs_pkg::ROW_W'(1)) ? lmrs_pkg::DELAY_W'(cfg.extra) : '0);
  assign delay_dec   = (delay != '0) ? delay - 1'b1 : delay;
  assign fetch       = tick && ((phase == lmrs_pkg::PH_COLDATA)
                             || (phase == lmrs_pkg::PH_WAIT && period_done));
  assign frame_start = fetch && ((phase == lmrs_pkg::PH_WAIT) || (row == '0 && col == '0));

  always_comb begin
    phase_next = phase;
    if (tick) begin
      case (phase)
        lmrs_pkg::PH_COLDATA: phase_next = lmrs_pkg::PH_CLKHI;
        lmrs_pkg::PH_CLKHI:   phase_next = lmrs_pkg::PH_CLKLO;
        lmrs_pkg::PH_CLKLO: begin
          if (!last_col) begin
            phase_next = lmrs_pkg::PH_COLDATA;
          end else if (delay_load != '0) begin
            phase_next = lmrs_pkg::PH_SETTLE;
          end else begin
            phase_next = lmrs_pkg::PH_OELOW;
          end
        end
        lmrs_pkg::PH_SETTLE: begin
          if (delay_dec == '0) begin
            phase_next = lmrs_pkg::PH_OELOW;
          end
        end
        lmrs_pkg::PH_OELOW:   phase_next = lmrs_pkg::PH_LATHI;
        lmrs_pkg::PH_LATHI:   phase_next = lmrs_pkg::PH_LATLO;
        lmrs_pkg::PH_LATLO:   phase_next = lmrs_pkg::PH_ROWDATA;
        lmrs_pkg::PH_ROWDATA: phase_next = lmrs_pkg::PH_RCLKHI;
        lmrs_pkg::PH_RCLKHI:  phase_next = lmrs_pkg::PH_RCLKLO;
        lmrs_pkg::PH_RCLKLO:  phase_next = lmrs_pkg::PH_OEHI;
        lmrs_pkg::PH_OEHI: begin
          phase_next = last_row ? lmrs_pkg::PH_WAIT : lmrs_pkg::PH_COLDATA;
        end
        default: begin
          if (period_done) begin
            phase_next = lmrs_pkg::PH_CLKHI;
          end
        end
      endcase
    end
  end

  always_comb begin
    col_next     = col;
    row_next     = row;
    delay_next   = delay;
    elapsed_next = elapsed;
    frames_next  = frames;
    pins_next    = pins;
    if (tick) begin
      elapsed_next = elapsed_inc;
      case (phase)
        lmrs_pkg::PH_CLKHI: pins_next.cc = 1'b1;
        lmrs_pkg::PH_CLKLO: begin
          pins_next.cc = 1'b0;
          if (last_col) begin
            col_next   = '0;
            delay_next = delay_load;
          end else begin
            col_next = col + 1'b1;
          end
        end
        lmrs_pkg::PH_SETTLE:  delay_next   = delay_dec;
        lmrs_pkg::PH_OELOW:   pins_next.oe = 1'b0;
        lmrs_pkg::PH_LATHI:   pins_next.cl = 1'b1;
        lmrs_pkg::PH_LATLO:   pins_next.cl = 1'b0;
        lmrs_pkg::PH_ROWDATA: pins_next.rd = (row == '0);
        lmrs_pkg::PH_RCLKHI:  pins_next.rc = 1'b1;
        lmrs_pkg::PH_RCLKLO:  pins_next.rc = 1'b0;
        lmrs_pkg::PH_OEHI: begin
          pins_next.oe = 1'b1;
          row_next     = last_row ? '0 : row + 1'b1;
        end
        lmrs_pkg::PH_WAIT: begin
          if (period_done) begin
            col_next = '0;
            row_next = '0;
          end
        end
        default: begin
        end
      endcase
      if (frame_start) begin
        frames_next  = frames + 1'b1;
        elapsed_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= lmrs_pkg::PH_COLDATA;
      col     <= '0;
      row     <= '0;
      delay   <= '0;
      elapsed <= '0;
      frames  <= '0;
      pins    <= '{cc: 1'b0, cl: 1'b0, rd: 1'b0, rc: 1'b0, oe: 1'b1};
    end else begin
      phase   <= phase_next;
      col     <= col_next;
      row     <= row_next;
      delay   <= delay_next;
      elapsed <= elapsed_next;
      frames  <= frames_next;
      pins    <= pins_next;
    end
  end

  always_comb begin
    upd          = '0;
    upd.rd_en    = fetch && !blank;
    upd.rd_addr  = lmrs_pkg::MEM_AW'(row) * lmrs_pkg::MEM_AW'(lmrs_pkg::COLUMNS)
                 + lmrs_pkg::MEM_AW'(col);
    upd.cd_load  = fetch;
    upd.cd_blank = blank;
    upd.pins     = pins_next;
    upd.frames   = frames_next;
  end

endmodule

// File: rtl/led_matrix_row_scan.sv
// ----------------------------------------------------------------------------
// led_matrix_row_scan
// Row-scan refresh sequencer for a monochrome LED matrix with a one-bit
// frame store written by pixel items and advanced by tick items.
// An accepted item is registered in a pending stage and then in the output
// stage, which offers its result item. Throughput: one item per cycle;
// each item needs at most one frame store access, a write or a read.
// Apart from reset and the clearing pass, the input stalls only while both
// stages are held. Reset: control and pins return to their idle levels,
// then all 8192 pixels of the frame store are cleared, during which no item
// is accepted; configuration writes are taken throughout.
// ----------------------------------------------------------------------------
module led_matrix_row_scan (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [lmrs_pkg::CFG_IW-1:0] cfg_index,
  input  logic [lmrs_pkg::CFG_W-1:0]  cfg_data,
  lmrs_in_if.sink                     item_in,
  lmrs_out_if.source                  result_out
);

  lmrs_pkg::cfg_t                cfg;
  lmrs_pkg::scan_upd_t           upd;
  lmrs_pkg::scan_upd_t           p_upd;
  logic                          p_valid;
  logic                          p_move;
  logic                          accept;
  logic                          tick;
  logic                          pix_we;
  logic                          rdata;
  logic                          busy;
  logic                          out_valid;
  logic                          out_cd;
  lmrs_pkg::pins_t               out_pins;
  logic [lmrs_pkg::FRAME_W-1:0]  out_frames;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.settle <= lmrs_pkg::RST_SETTLE;
      cfg.extra  <= lmrs_pkg::RST_EXTRA;
      cfg.period <= lmrs_pkg::RST_PERIOD;
    end else if (cfg_we) begin
      case (cfg_index)
        lmrs_pkg::CFG_SETTLE: cfg.settle <= cfg_data[lmrs_pkg::SETTLE_W-1:0];
        lmrs_pkg::CFG_EXTRA:  cfg.extra  <= cfg_data[lmrs_pkg::SETTLE_W-1:0];
        lmrs_pkg::CFG_PERIOD: cfg.period <= cfg_data[lmrs_pkg::TICK_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign p_move        = p_valid && (!out_valid || result_out.ready);
  assign item_in.ready = !rst && !busy && (!p_valid || p_move);
  assign accept        = item_in.valid && item_in.ready;
  assign tick          = accept && (item_in.opcode == lmrs_pkg::OP_TICK);
  assign pix_we        = accept && (item_in.opcode == lmrs_pkg::OP_WRITE)
                       && (32'(item_in.pixel_address) < lmrs_pkg::MEM_DEPTH);

  lmrs_scan_ctrl u_scan (
    .clk  (clk),
    .rst  (rst),
    .tick (tick),
    .cfg  (cfg),
    .upd  (upd)
  );

  lmrs_frame_mem u_mem (
    .clk   (clk),
    .rst   (rst),
    .we    (pix_we),
    .waddr (lmrs_pkg::MEM_AW'(item_in.pixel_address)),
    .wdata (item_in.pixel_on),
    .re    (upd.rd_en),
    .raddr (upd.rd_addr),
    .rdata (rdata),
    .busy  (busy)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (accept) begin
      p_valid <= 1'b1;
    end else if (p_move) begin
      p_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p_upd <= upd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (p_move) begin
      out_valid <= 1'b1;
    end else if (result_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_cd     <= 1'b0;
      out_pins   <= '{cc: 1'b0, cl: 1'b0, rd: 1'b0, rc: 1'b0, oe: 1'b1};
      out_frames <= '0;
    end else if (p_move) begin
      if (p_upd.cd_load) begin
        out_cd <= p_upd.cd_blank ? 1'b0 : rdata;
      end
      out_pins   <= p_upd.pins;
      out_frames <= p_upd.frames;
    end
  end

  assign result_out.valid       = out_valid;
  assign result_out.col_sdi     = out_cd;
  assign result_out.col_sck     = out_pins.cc;
  assign result_out.col_lat     = out_pins.cl;
  assign result_out.row_sdi     = out_pins.rd;
  assign result_out.row_sck     = out_pins.rc;
  assign result_out.oe_n        = out_pins.oe;
  assign result_out.frame_count = out_frames;

  a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (rst)
    busy |-> !item_in.ready)
    else $error("Item channel ready while the frame store is being cleared.");

  a_stage_holds: assert property (@(posedge clk) disable iff (rst)
    (p_valid && !p_move) |=> (p_valid && $stable(p_upd)))
    else $error("Pending item lost or changed while the output was stalled.");

  a_frame_step: assert property (@(posedge clk) disable iff (rst)
    p_move |=> ((result_out.frame_count == $past(result_out.frame_count))
             || (result_out.frame_count == $past(result_out.frame_count) + 32'd1)))
    else $error("Frame count advanced by more than one for a single item.");

  a_pulse_dark: assert property (@(posedge clk) disable iff (rst)
    (result_out.col_lat || result_out.row_sck) |-> !result_out.oe_n)
    else $error("Latch or row clock pulsed while output enable was high.");

endmodule

// File: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the LED matrix row scan driver. Pixel writes and
// scan ticks are offered on the input channel while both channels idle at
// random. A scoreboard tracks the frame store and the scan sequencer and
// compares every result item, field by field, with the pin levels and frame
// count it predicts. Several register settings, zero and the largest among
// them, are applied between runs while the scan steps through its rows.
// ----------------------------------------------------------------------------
module testbench;

  localparam int JUNK_W = lmrs_pkg::CFG_W - lmrs_pkg::SETTLE_W;

  typedef struct packed {
    logic                         col_sdi;
    logic                         col_sck;
    logic                         col_lat;
    logic                         row_sdi;
    logic                         row_sck;
    logic                         oe_n;
    logic [lmrs_pkg::FRAME_W-1:0] frame_count;
  } scan_result_t;

  class scan_scoreboard;
    bit                           frame_bits [lmrs_pkg::MEM_DEPTH];
    lmrs_pkg::cfg_t               regs;
    lmrs_pkg::phase_t             phase;
    logic [lmrs_pkg::COL_W:0]     col;
    logic [lmrs_pkg::ROW_W-1:0]   row;
    logic [lmrs_pkg::DELAY_W-1:0] delay;
    logic [lmrs_pkg::TICK_W-1:0]  elapsed;
    scan_result_t                 levels;
    scan_result_t                 expected_levels [$];
    int                           errors;
    int                           checked;

    function new();
      foreach (frame_bits[i]) frame_bits[i] = 1'b0;
      regs = '{settle: lmrs_pkg::RST_SETTLE, extra: lmrs_pkg::RST_EXTRA,
               period: lmrs_pkg::RST_PERIOD};
      phase = lmrs_pkg::PH_COLDATA;
      col = '0;
      row = '0;
      delay = '0;
      elapsed = '0;
      levels = '0;
      levels.oe_n = 1'b1;
      errors = 0;
      checked = 0;
    endfunction

    function void set_reg(logic [lmrs_pkg::CFG_IW-1:0] idx, logic [lmrs_pkg::CFG_W-1:0] data);
      case (idx)
        lmrs_pkg::CFG_SETTLE: regs.settle = data[lmrs_pkg::SETTLE_W-1:0];
        lmrs_pkg::CFG_EXTRA:  regs.extra = data[lmrs_pkg::SETTLE_W-1:0];
        lmrs_pkg::CFG_PERIOD: regs.period = data[lmrs_pkg::TICK_W-1:0];
        default: ;
      endcase
    endfunction

    function void load_column();
      if (row == 0 && col == 0) begin
        levels.frame_count++;
        elapsed = '0;
      end
      if (row < lmrs_pkg::ROWS && col < lmrs_pkg::COLUMNS) begin
        levels.col_sdi = frame_bits[row * lmrs_pkg::COLUMNS + col];
      end else begin
        levels.col_sdi = 1'b0;
      end
      phase = lmrs_pkg::PH_CLKHI;
    endfunction

    function void advance_scan();
      if (elapsed != lmrs_pkg::TICK_MAX) elapsed++;
      case (phase)
        lmrs_pkg::PH_COLDATA: load_column();
        lmrs_pkg::PH_CLKHI: begin
          levels.col_sck = 1'b1;
          phase = lmrs_pkg::PH_CLKLO;
        end
        lmrs_pkg::PH_CLKLO: begin
          levels.col_sck = 1'b0;
          col++;
          if (col >= lmrs_pkg::COLUMNS) begin
            col = '0;
            delay = {1'b0, regs.settle} + ((row == 1) ? {1'b0, regs.extra} : '0);
            phase = (delay != 0) ? lmrs_pkg::PH_SETTLE : lmrs_pkg::PH_OELOW;
          end else begin
            phase = lmrs_pkg::PH_COLDATA;
          end
        end
        lmrs_pkg::PH_SETTLE: begin
          if (delay != 0) delay--;
          if (delay == 0) phase = lmrs_pkg::PH_OELOW;
        end
        lmrs_pkg::PH_OELOW: begin
          levels.oe_n = 1'b0;
          phase = lmrs_pkg::PH_LATHI;
        end
        lmrs_pkg::PH_LATHI: begin
          levels.col_lat = 1'b1;
          phase = lmrs_pkg::PH_LATLO;
        end
        lmrs_pkg::PH_LATLO: begin
          levels.col_lat = 1'b0;
          phase = lmrs_pkg::PH_ROWDATA;
        end
        lmrs_pkg::PH_ROWDATA: begin
          levels.row_sdi = (row == 0);
          phase = lmrs_pkg::PH_RCLKHI;
        end
        lmrs_pkg::PH_RCLKHI: begin
          levels.row_sck = 1'b1;
          phase = lmrs_pkg::PH_RCLKLO;
        end
        lmrs_pkg::PH_RCLKLO: begin
          levels.row_sck = 1'b0;
          phase = lmrs_pkg::PH_OEHI;
        end
        lmrs_pkg::PH_OEHI: begin
          levels.oe_n = 1'b1;
          row++;
          if (row >= lmrs_pkg::ROWS + 1) begin
            row = '0;
            phase = lmrs_pkg::PH_WAIT;
          end else begin
            phase = lmrs_pkg::PH_COLDATA;
          end
        end
        default: begin
          if (elapsed >= regs.period) begin
            col = '0;
            row = '0;
            load_column();
          end
        end
      endcase
    endfunction

    function void note_item(logic op, logic [lmrs_pkg::ADDR_W-1:0] addr, logic on);
      if (op == lmrs_pkg::OP_WRITE) begin
        if (addr < lmrs_pkg::MEM_DEPTH) frame_bits[addr] = on;
      end else begin
        advance_scan();
      end
      expected_levels.push_back(levels);
    endfunction

    function int pending();
      return expected_levels.size();
    endfunction

    task report(string msg);
      errors++;
      $display("ERROR: %s", msg);
    endtask

    task compare_pin(string name, logic got, logic want);
      if (got !== want) begin
        report($sformatf("result %0d %s is %0h, expected %0h", checked, name, got, want));
      end
    endtask

    task compare_count(logic [lmrs_pkg::FRAME_W-1:0] got, logic [lmrs_pkg::FRAME_W-1:0] want);
      if (got !== want) begin
        report($sformatf("result %0d frame_count is %0h, expected %0h", checked, got, want));
      end
    endtask

    task check_result(scan_result_t got);
      scan_result_t want;
      checked++;
      if (expected_levels.size() == 0) begin
        report($sformatf("result %0d arrived with nothing expected", checked));
      end else begin
        want = expected_levels.pop_front();
        compare_pin("col_sdi", got.col_sdi, want.col_sdi);
        compare_pin("col_sck", got.col_sck, want.col_sck);
        compare_pin("col_lat", got.col_lat, want.col_lat);
        compare_pin("row_sdi", got.row_sdi, want.row_sdi);
        compare_pin("row_sck", got.row_sck, want.row_sck);
        compare_pin("oe_n", got.oe_n, want.oe_n);
        compare_count(got.frame_count, want.frame_count);
      end
    endtask
  endclass

  logic                        clk = 1'b0;
  logic                        rst;
  logic                        cfg_we;
  logic [lmrs_pkg::CFG_IW-1:0] cfg_index;
  logic [lmrs_pkg::CFG_W-1:0]  cfg_data;
  logic                        calm;
  logic                        hold_off;
  int                          items_taken = 0;

  lmrs_in_if  in_ch ();
  lmrs_out_if out_ch ();

  led_matrix_row_scan u_top (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .item_in    (in_ch),
    .result_out (out_ch)
  );

  scan_scoreboard sb = new();

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic offer_item(logic op, logic [lmrs_pkg::ADDR_W-1:0] addr, logic on);
    while (!calm && $urandom_range(99) < 31) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.opcode        <= op;
    in_ch.pixel_address <= addr;
    in_ch.pixel_on      <= on;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    sb.note_item(op, addr, on);
    items_taken++;
  endtask

  task automatic offer_random_tick();
    offer_item(lmrs_pkg::OP_TICK,
               lmrs_pkg::ADDR_W'($urandom_range(lmrs_pkg::MEM_DEPTH - 1)),
               1'($urandom_range(1)));
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    for (int c = 0; c < 5000 && sb.pending() != 0; c++) @(posedge clk);
  endtask

  task automatic program_regs(logic [lmrs_pkg::SETTLE_W-1:0] settle,
                              logic [lmrs_pkg::SETTLE_W-1:0] extra,
                              logic [lmrs_pkg::TICK_W-1:0] period);
    logic [JUNK_W-1:0]          junk;
    logic [lmrs_pkg::CFG_W-1:0] data;
    junk = JUNK_W'($urandom_range(2 ** JUNK_W - 1));
    data = {junk, settle};
    cfg_we    <= 1'b1;
    cfg_index <= lmrs_pkg::CFG_SETTLE;
    cfg_data  <= data;
    sb.set_reg(lmrs_pkg::CFG_SETTLE, data);
    @(posedge clk);
    junk = JUNK_W'($urandom_range(2 ** JUNK_W - 1));
    data = {junk, extra};
    cfg_index <= lmrs_pkg::CFG_EXTRA;
    cfg_data  <= data;
    sb.set_reg(lmrs_pkg::CFG_EXTRA, data);
    @(posedge clk);
    cfg_index <= lmrs_pkg::CFG_PERIOD;
    cfg_data  <= period;
    sb.set_reg(lmrs_pkg::CFG_PERIOD, period);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_phase(logic [lmrs_pkg::SETTLE_W-1:0] settle,
                           logic [lmrs_pkg::SETTLE_W-1:0] extra,
                           logic [lmrs_pkg::TICK_W-1:0] period, int n, int write_pct,
                           int calm_items, int pause_at);
    program_regs(settle, extra, period);
    for (int i = 0; i < n; i++) begin
      calm <= (i < calm_items);
      if (i == pause_at) drain();
      if ($urandom_range(99) < write_pct) begin
        offer_item(lmrs_pkg::OP_WRITE,
                   lmrs_pkg::ADDR_W'($urandom_range(lmrs_pkg::MEM_DEPTH - 1)),
                   1'($urandom_range(1)));
      end else begin
        offer_random_tick();
      end
    end
    calm <= 1'b0;
    drain();
    repeat (4) @(posedge clk);
  endtask

  initial begin
    scan_result_t got;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        got = '{col_sdi: out_ch.col_sdi, col_sck: out_ch.col_sck,
                col_lat: out_ch.col_lat, row_sdi: out_ch.row_sdi,
                row_sck: out_ch.row_sck, oe_n: out_ch.oe_n,
                frame_count: out_ch.frame_count};
        sb.check_result(got);
      end
      out_ch.ready <= !rst && !hold_off && (calm || $urandom_range(99) >= 31);
    end
  end

  initial begin
    hold_off = 1'b0;
    wait (items_taken >= 700);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (400) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    rst                 = 1'b1;
    cfg_we              = 1'b0;
    cfg_index           = '0;
    cfg_data            = '0;
    calm                = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.opcode        = lmrs_pkg::OP_TICK;
    in_ch.pixel_address = '0;
    in_ch.pixel_on      = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    offer_item(lmrs_pkg::OP_WRITE, '0, 1'b1);
    offer_item(lmrs_pkg::OP_WRITE, 13'd1, 1'b1);
    offer_item(lmrs_pkg::OP_WRITE, 13'd1, 1'b0);
    offer_item(lmrs_pkg::OP_WRITE, 13'd2, 1'b1);
    offer_item(lmrs_pkg::OP_WRITE, 13'd127, 1'b1);
    offer_item(lmrs_pkg::OP_WRITE, 13'd128, 1'b1);
    offer_item(lmrs_pkg::OP_WRITE, '1, 1'b1);
    repeat (8) offer_random_tick();
    offer_item(lmrs_pkg::OP_WRITE, 13'd3, 1'b1);
    repeat (6) offer_random_tick();
    drain();
    repeat (4) @(posedge clk);

    run_phase(10'd90, 10'd300, 16'd16667, 700, 30, 0, 400);
    run_phase(10'd0, 10'd0, 16'd0, 400, 5, 300, -1);
    run_phase(10'd1, 10'd1023, 16'd40000, 200, 3, 0, -1);
    run_phase(10'd1023, 10'd1023, 16'd65535, 200, 2, 0, -1);

    if (sb.pending() != 0) begin
      sb.report($sformatf("%0d expected results never arrived", sb.pending()));
    end
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
